>>> src/sipq_pkg.sv
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and constants for the sorted-insert priority queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sipq_pkg;

    // Field widths of one stored entry.
    localparam int KEY_W      = 16;
    localparam int SENDER_W   = 8;
    localparam int RECEIVER_W = 8;
    localparam int ENTRY_W    = KEY_W + SENDER_W + RECEIVER_W;
    localparam int STATUS_W   = 2;
    localparam int CAP_W      = 6;
    localparam int COUNT_W    = 6;

    // Command codes.
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // Status codes returned with every transaction.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ_CMP,
        ST_ENQ_WRITE,
        ST_DEQ_READ,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

>>> src/sipq_ram.sv
// ----------------------------------------------------------------------------
// sipq_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/sorted_insert_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_unit
// Priority queue kept sorted in a circular RAM. An enqueue walks back from
// the tail, moving each larger-keyed entry one slot toward the tail, then
// writes the new entry, so equal keys leave in arrival order. A dequeue
// removes the head entry, which holds the smallest key.
// ----------------------------------------------------------------------------
// Sequence: an enqueue passes through ST_ENQ_CMP and/or ST_ENQ_WRITE, then ST_RESP;
// a dequeue through ST_DEQ_READ and ST_RESP; a rejected transaction goes to ST_RESP.
// Throughput: one transaction at a time, accepted again the cycle after its
// result is loaded; the walk moves one entry per cycle.
// Reset: synchronous, active low; empties the queue and sets the capacity
// limit to 32. The RAM contents are not cleared.
`default_nettype none

module sorted_insert_priority_queue_unit #(
    parameter int DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration register.
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_data,
    // Input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_cmd,
    input  wire logic [15:0] i_in_key,
    input  wire logic [7:0]  i_in_sender,
    input  wire logic [7:0]  i_in_receiver,
    // Output channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [15:0]      o_out_key,
    output logic [7:0]       o_out_sender,
    output logic [7:0]       o_out_receiver,
    output logic [5:0]       o_entry_count
);

    import sipq_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
    localparam logic [AW-1:0]    LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);
    localparam logic [AW:0]      DEPTH_SUM = (AW + 1)'(DEPTH);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [CAP_W-1:0]      r_cap;
    logic [AW-1:0]         r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [AW-1:0]         r_slot, n_slot;
    logic [CNT_W-1:0]      r_pos, n_pos;
    logic [ENTRY_W-1:0]    r_word, n_word;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic [ENTRY_W-1:0]    r_res_word, n_res_word;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [ENTRY_W-1:0]    r_out_word;
    logic [COUNT_W-1:0]    r_out_count;

    // RAM port signals.
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [ENTRY_W-1:0]    mem_rdata;

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    logic                  in_fire;
    logic                  out_free;
    logic [CMP_W-1:0]      cap_eff;
    logic                  is_full;
    logic [AW:0]           tail_sum;
    logic [AW-1:0]         tail_slot;
    logic [AW-1:0]         tail_prev;
    logic [AW-1:0]         slot_prev;
    logic [AW-1:0]         slot_prev2;
    logic [AW-1:0]         head_next;
    logic                  key_less;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Effective capacity: zero acts as one, anything above DEPTH acts as DEPTH.
    always_comb begin
        cap_eff = (r_cap == '0) ? CMP_W'(1) : CMP_W'(r_cap);
        if (cap_eff > DEPTH_CMP) begin
            cap_eff = DEPTH_CMP;
        end
    end
    assign is_full = CMP_W'(r_count) >= cap_eff;

    // Tail slot is head plus count, wrapped once around the store.
    assign tail_sum   = (AW + 1)'(r_head) + (AW + 1)'(r_count);
    assign tail_slot  = (tail_sum >= DEPTH_SUM) ? AW'(tail_sum - DEPTH_SUM) : AW'(tail_sum);
    assign tail_prev  = (tail_slot == '0) ? LAST_SLOT : tail_slot - AW'(1);
    assign slot_prev  = (r_slot == '0) ? LAST_SLOT : r_slot - AW'(1);
    assign slot_prev2 = (slot_prev == '0) ? LAST_SLOT : slot_prev - AW'(1);
    assign head_next  = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);

    // Shared comparator: the new key against the entry just read.
    assign key_less = r_word[ENTRY_W-1 -: KEY_W] < mem_rdata[ENTRY_W-1 -: KEY_W];

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_cmd == CMD_DEQUEUE) begin
                        n_state = (r_count == '0) ? ST_RESP : ST_DEQ_READ;
                    end else if (is_full) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = (r_count == '0) ? ST_ENQ_WRITE : ST_ENQ_CMP;
                    end
                end
            end
            ST_ENQ_CMP: begin
                if (!key_less) begin
                    n_state = ST_RESP;
                end else if (r_pos == CNT_W'(1)) begin
                    n_state = ST_ENQ_WRITE;
                end
            end
            ST_ENQ_WRITE: begin
                n_state = ST_RESP;
            end
            ST_DEQ_READ: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output and RAM control logic
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_slot;
        mem_wdata  = r_word;
        mem_raddr  = r_head;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                // Start the walk by reading the last held entry.
                if (i_cmd == CMD_ENQUEUE) begin
                    mem_raddr = tail_prev;
                end
            end
            ST_ENQ_CMP: begin
                mem_raddr = slot_prev2;
                mem_we    = 1'b1;
                // A larger key moves one slot toward the tail; otherwise the
                // new entry lands in the freed slot.
                mem_wdata = key_less ? mem_rdata : r_word;
            end
            ST_ENQ_WRITE: begin
                mem_we = 1'b1;
            end
            ST_DEQ_READ, ST_RESP: begin
                mem_raddr = r_head;
            end
            default: begin
                mem_raddr = r_head;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_slot       = r_slot;
        n_pos        = r_pos;
        n_word       = r_word;
        n_res_status = r_res_status;
        n_res_word   = r_res_word;
        n_out_valid  = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_word       = {i_in_key, i_in_sender, i_in_receiver};
                    n_slot       = tail_slot;
                    n_pos        = r_count;
                    n_res_word   = '0;
                    n_res_status = STATUS_OK;
                    if (i_cmd == CMD_DEQUEUE) begin
                        if (r_count == '0) begin
                            n_res_status = STATUS_EMPTY;
                        end
                    end else if (is_full) begin
                        n_res_status = STATUS_FULL;
                    end
                end
            end
            ST_ENQ_CMP: begin
                if (key_less) begin
                    n_slot = slot_prev;
                    n_pos  = r_pos - CNT_W'(1);
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            ST_ENQ_WRITE: begin
                n_count = r_count + CNT_W'(1);
            end
            ST_DEQ_READ: begin
                n_res_word = mem_rdata;
                n_head     = head_next;
                n_count    = r_count - CNT_W'(1);
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_pos        <= n_pos;
        r_word       <= n_word;
        r_res_status <= n_res_status;
        r_res_word   <= n_res_word;
        // The result transaction is loaded once the output register is free.
        if (r_state == ST_RESP && out_free) begin
            r_out_status <= r_res_status;
            r_out_word   <= r_res_word;
            r_out_count  <= COUNT_W'(r_count);
        end
    end

    // ------------------------------------------------------------------
    // Entry store
    // ------------------------------------------------------------------
    sipq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output ports.
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_key      = r_out_word[ENTRY_W-1 -: KEY_W];
    assign o_out_sender   = r_out_word[RECEIVER_W +: SENDER_W];
    assign o_out_receiver = r_out_word[RECEIVER_W-1:0];
    assign o_entry_count  = r_out_count;

endmodule

`default_nettype wire
